FILE: hdl/gmle_pkg.sv
package gmle_pkg;

    // Pixel and field widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    // Row width after reset
    localparam int ROW_WIDTH_RST = 640;

    // Luminosity weights in hundredths: 0.21, 0.72, 0.07
    localparam int WEIGHT_R = 21;
    localparam int WEIGHT_G = 72;
    localparam int WEIGHT_B = 7;

    // Weighted sum peaks at 25500, so 15 bits hold it
    localparam int SUM_W = 15;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 25600
    localparam int RECIP_W     = 13;
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // tuser codes on the input side
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] grey;
    } result_t;

    function automatic logic [SUM_W-1:0] luma_sum(
        input logic [PIX_W-1:0] red,
        input logic [PIX_W-1:0] green,
        input logic [PIX_W-1:0] blue
    );
        logic [SUM_W-1:0] r_term;
        logic [SUM_W-1:0] g_term;
        logic [SUM_W-1:0] b_term;
        r_term = SUM_W'(red)   * SUM_W'(WEIGHT_R);
        g_term = SUM_W'(green) * SUM_W'(WEIGHT_G);
        b_term = SUM_W'(blue)  * SUM_W'(WEIGHT_B);
        return r_term + g_term + b_term;
    endfunction

    function automatic logic [PIX_W-1:0] div_by_100(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(RECIP);
        return prod[RECIP_SHIFT +: PIX_W];
    endfunction

endpackage

FILE: hdl/greyscale_mirror_line_engine_top.sv
// Greyscale mirror line engine. RGB pixels arrive in raster order as beats on
// the s_ side (tuser low) and each is turned into grey = floor((21R + 72G +
// 7B) / 100) and written into one bank of a ping-pong line store. Once a full
// row is held, every further beat (pixel or drain) reads the held row back in
// mirrored order from the other bank and gives one beat on the m_ side, with
// tlast on the final pixel of each row; so output lags input by one row and the
// first row of an image gives no output. At the end of an image send drain
// beats (tuser high) to empty the last row; a drain beat with no row held is
// swallowed. Rate: one beat per clock in both directions, sustained while
// m_tready stays high. A beat passes the input, weighted sum and line store
// read registers into an eight-entry output queue that absorbs back-pressure;
// s_tready falls only once that queue plus the beats in flight would fill it.
// row_width (1..MAX_WIDTH, saturated) is written via cfg_wr_en / cfg_wr_data
// by the user only while the engine is idle; the block does not enforce it.
// Writes do not reset the column or banks. Line store is undefined after reset.
module greyscale_mirror_line_engine_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,   // row_width

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [7:0] red, [15:8] green, [23:16] blue
    input  logic        s_tuser,       // mode: 0 pixel, 1 drain

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] grey
    output logic        m_tlast        // row_last
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W = COL_W + 1;
    localparam int MEM_D  = 2 ** ADDR_W;
    localparam int CMP_W  = (WW > gmle_pkg::CFG_W) ? WW : gmle_pkg::CFG_W;
    localparam int W_RST  = (gmle_pkg::ROW_WIDTH_RST > MAX_WIDTH) ?
                            MAX_WIDTH : gmle_pkg::ROW_WIDTH_RST;

    // ---------------------------------------------------------------
    // Row width, saturated to 1..MAX_WIDTH on write
    // ---------------------------------------------------------------
    logic [WW-1:0]    width_reg;
    logic [WW-1:0]    width_next;
    logic [CMP_W-1:0] cfg_ext;

    always_comb begin
        cfg_ext = CMP_W'(cfg_wr_data);
        if (cfg_ext == '0) begin
            width_next = WW'(1);
        end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
            width_next = WW'(MAX_WIDTH);
        end else begin
            width_next = cfg_ext[WW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WW'(W_RST);
        end else if (cfg_wr_en) begin
            width_reg <= width_next;
        end
    end

    // ---------------------------------------------------------------
    // Occupancy and input handshake
    // ---------------------------------------------------------------
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         res_valid_reg;
    logic [gmle_pkg::FIFO_CW-1:0] fifo_count_reg;
    logic [gmle_pkg::FIFO_CW-1:0] occupancy;
    logic                         s_accept;

    // every beat in flight counted as if it will give a result
    assign occupancy = fifo_count_reg + gmle_pkg::FIFO_CW'(v1_reg)
                     + gmle_pkg::FIFO_CW'(v2_reg) + gmle_pkg::FIFO_CW'(res_valid_reg);
    assign s_tready  = (occupancy < gmle_pkg::FIFO_CW'(gmle_pkg::FIFO_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic                       mode1_reg;
    logic [gmle_pkg::PIX_W-1:0] red1_reg;
    logic [gmle_pkg::PIX_W-1:0] green1_reg;
    logic [gmle_pkg::PIX_W-1:0] blue1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode1_reg  <= s_tuser;
            red1_reg   <= s_tdata[7:0];
            green1_reg <= s_tdata[15:8];
            blue1_reg  <= s_tdata[23:16];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: weighted sum
    // ---------------------------------------------------------------
    logic                       mode2_reg;
    logic [gmle_pkg::SUM_W-1:0] sum2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            mode2_reg <= mode1_reg;
            sum2_reg  <= gmle_pkg::luma_sum(red1_reg, green1_reg, blue1_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: divide, line store write/read, row control
    // ---------------------------------------------------------------
    logic [COL_W-1:0]           column_reg;
    logic [COL_W-1:0]           column_next;
    logic                       bank_reg;
    logic                       bank_next;
    logic                       row_pending_reg;
    logic                       row_pending_next;

    logic [gmle_pkg::PIX_W-1:0] grey_in;
    logic                       is_drain;
    logic                       busy;
    logic [WW-1:0]              col_ext;
    logic [WW-1:0]              col_inc;
    logic [WW-1:0]              pos_full;
    logic [COL_W-1:0]           rd_pos;
    logic                       row_end;
    logic                       mem_wr;
    logic                       mem_rd;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    logic [gmle_pkg::PIX_W-1:0] line_mem [MEM_D];
    logic [gmle_pkg::PIX_W-1:0] rd_data_reg;
    logic                       last3_reg;

    always_comb begin
        grey_in  = gmle_pkg::div_by_100(sum2_reg);
        is_drain = (mode2_reg == gmle_pkg::MODE_DRAIN);
        busy     = v2_reg && !(is_drain && !row_pending_reg);

        col_ext  = WW'(column_reg);
        col_inc  = col_ext + WW'(1);
        row_end  = (col_inc >= width_reg);

        // mirrored position; a column left past a shrunk width reads entry 0
        pos_full = width_reg - WW'(1) - col_ext;
        rd_pos   = (col_ext < width_reg) ? pos_full[COL_W-1:0] : '0;

        mem_wr   = v2_reg && !is_drain;
        mem_rd   = v2_reg && row_pending_reg;
        wr_addr  = {bank_reg, column_reg};
        rd_addr  = {~bank_reg, rd_pos};

        column_next      = column_reg;
        bank_next        = bank_reg;
        row_pending_next = row_pending_reg;
        if (busy) begin
            if (row_end) begin
                column_next = '0;
                if (is_drain) begin
                    row_pending_next = 1'b0;
                end else begin
                    bank_next        = ~bank_reg;
                    row_pending_next = 1'b1;
                end
            end else begin
                column_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg      <= '0;
            bank_reg        <= 1'b0;
            row_pending_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else begin
            column_reg      <= column_next;
            bank_reg        <= bank_next;
            row_pending_reg <= row_pending_next;
            res_valid_reg   <= mem_rd;
        end
    end

    // write bank and read bank always differ, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            line_mem[wr_addr] <= grey_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            rd_data_reg <= line_mem[rd_addr];
            last3_reg   <= row_end;
        end
    end

    // ---------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------
    gmle_pkg::result_t            fifo_mem [gmle_pkg::FIFO_DEPTH];
    logic [gmle_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [gmle_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic                         push;
    logic                         pop;
    gmle_pkg::result_t            head;

    assign push = res_valid_reg;
    assign pop  = m_tvalid && m_tready;
    assign head = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= '{last: last3_reg, grey: rd_data_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + gmle_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + gmle_pkg::FIFO_AW'(1);
            end
            if (push && !pop) begin
                fifo_count_reg <= fifo_count_reg + gmle_pkg::FIFO_CW'(1);
            end else if (pop && !push) begin
                fifo_count_reg <= fifo_count_reg - gmle_pkg::FIFO_CW'(1);
            end
        end
    end

    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tdata  = head.grey;
    assign m_tlast  = head.last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> fifo_count_reg < gmle_pkg::FIFO_CW'(gmle_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= gmle_pkg::FIFO_CW'(gmle_pkg::FIFO_DEPTH))
        else $error("beats in flight exceed queue space");

    a_result_needs_row: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> $past(row_pending_reg))
        else $error("result read with no stored row");

    a_pending_on_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(row_pending_reg) |-> bank_reg != $past(bank_reg))
        else $error("row held without bank swap");

endmodule
